### rtl/i64dec_pkg.sv
package i64dec_pkg;

    // Input word and BCD accumulator geometry
    localparam int NUM_W   = 64;
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = 20;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(NUM_W);

    // Result field widths
    localparam int CHAR_W = 6;
    localparam int LEN_W  = 5;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

endpackage

### rtl/i64dec_conv.sv
module i64dec_conv
    import i64dec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [NUM_W-1:0]   mag,
    input  logic               shift,
    output logic               done,
    output logic [DIGIT_W-1:0] top_digit
);

    logic [NUM_W-1:0] bin_reg;
    logic [NUM_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [BCD_W-1:0] bcd_adj;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             run_reg;
    logic             run_next;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign done      = run_reg && (cnt_reg == CNT_W'(NUM_W - 1));
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (load)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // one magnitude bit per cycle, MSB first
            bin_next = {bin_reg[NUM_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (done)
            begin
                run_next = 1'b0;
            end
        end
        else if (shift)
        begin
            bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

### rtl/signed_int64_to_decimal_ascii_core.sv
// Signed 64-bit to decimal ASCII. An item (number) is taken at a rising edge with start
// high and busy low; its text then comes out one character per cycle, most significant
// first, each on ascii_char/text_length/last_char for exactly one cycle with char_valid
// high. The receiver cannot stall, so it must take every character as it appears. A
// negative number gets a leading minus sign; zero prints as a single '0'. text_length
// (sign included, 1..20) is the same on every character, and last_char marks the end.
// Timing is set by the bit-serial double-dabble unit and the digit shift-out that follows:
// the conversion runs first, then the leading-zero skip and the digit output. The skip
// drops one zero per cycle and then hands over to the output, and the minus sign leaves
// on that hand-over edge, so the sign adds no time. The last character therefore shows
// equally long after the accepting edge for every value, and no new item is taken while
// one is still in work. busy is low again in the cycle that shows the last character,
// so a new start may be given there.
module signed_int64_to_decimal_ascii_core
    import i64dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [NUM_W-1:0]  number,
    output logic              char_valid,
    output logic [CHAR_W-1:0] ascii_char,
    output logic [LEN_W-1:0]  text_length,
    output logic              last_char
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               neg_reg;
    logic               neg_next;
    logic [LEN_W-1:0]   ndig_reg;   // digits left in the accumulator
    logic [LEN_W-1:0]   ndig_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;

    logic               valid_reg;
    logic               valid_next;
    logic [CHAR_W-1:0]  char_reg;
    logic [CHAR_W-1:0]  char_next;
    logic [LEN_W-1:0]   tlen_reg;
    logic [LEN_W-1:0]   tlen_next;
    logic               last_reg;
    logic               last_next;

    logic               conv_load;
    logic [NUM_W-1:0]   conv_mag;
    logic               conv_shift;
    logic               conv_done;
    logic [DIGIT_W-1:0] top_digit;
    logic               accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Unsigned negation: the most negative value gives 2^63 exactly.
    assign conv_mag  = number[NUM_W-1] ? (NUM_W'(0) - number) : number;
    assign conv_load = accept;

    i64dec_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (conv_load),
        .mag       (conv_mag),
        .shift     (conv_shift),
        .done      (conv_done),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        ndig_next  = ndig_reg;
        len_next   = len_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        tlen_next  = tlen_reg;
        last_next  = last_reg;
        conv_shift = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = number[NUM_W-1];
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    ndig_next  = LEN_W'(DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if ((top_digit == '0) && (ndig_reg != LEN_W'(1)))
                begin
                    conv_shift = 1'b1;
                    ndig_next  = ndig_reg - LEN_W'(1);
                end
                else
                begin
                    len_next   = ndig_reg + LEN_W'(neg_reg);
                    state_next = S_EMIT;
                    if (neg_reg)
                    begin
                        valid_next = 1'b1;
                        char_next  = CH_MINUS;
                        tlen_next  = ndig_reg + LEN_W'(1);
                        last_next  = 1'b0;
                    end
                end
            end
            S_EMIT:
            begin
                valid_next = 1'b1;
                char_next  = CH_ZERO + CHAR_W'(top_digit);
                tlen_next  = len_reg;
                last_next  = (ndig_reg == LEN_W'(1));
                conv_shift = 1'b1;
                ndig_next  = ndig_reg - LEN_W'(1);
                if (ndig_reg == LEN_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            neg_reg   <= 1'b0;
            ndig_reg  <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            neg_reg   <= neg_next;
            ndig_reg  <= ndig_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        tlen_reg <= tlen_next;
        last_reg <= last_next;
    end

    assign char_valid  = valid_reg;
    assign ascii_char  = char_reg;
    assign text_length = tlen_reg;
    assign last_char   = last_reg;

endmodule

### rtl/i64dec_check.sv
module i64dec_check
    import i64dec_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              char_valid,
    input logic [CHAR_W-1:0] ascii_char,
    input logic [LEN_W-1:0]  text_length,
    input logic              last_char
);

    // accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    // characters of one text are contiguous with a constant length
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !last_char) |=> (char_valid && text_length == $past(text_length)))
        else $error("text broken or length changed mid-text");

    // gap after the final character
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && last_char) |=> !char_valid)
        else $error("character right after last_char");

    // only the final character may appear while idle
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !last_char) |-> busy)
        else $error("mid-text character while idle");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (ascii_char == CH_MINUS ||
                        (ascii_char >= CH_ZERO && ascii_char <= CH_ZERO + CHAR_W'(9))))
        else $error("bad character code");

endmodule

bind signed_int64_to_decimal_ascii_core i64dec_check u_check (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import i64dec_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 7;
    localparam int RAND_ITEMS = 220;
    localparam int DRAIN_WAIT = 100;     // a margin beyond the start-to-last span of one item
    localparam int CYCLE_CAP  = 400000;  // well above 242 items with the longest gaps between them
    localparam int DIR_N      = 22;

    // One expected character of the decimal text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              last;
    } text_char_t;

    // Shapes of random numbers
    typedef enum int {
        SHAPE_FULL,     // any 64-bit word
        SHAPE_SHORT,    // a few digits
        SHAPE_DECADE,   // power of ten, -1/0/+1
        SHAPE_SCALED,   // full word shifted down, so any digit count
        SHAPE_EDGE      // near the most negative / largest positive value
    } shape_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [NUM_W-1:0]  number = '0;
    logic              busy;
    logic              char_valid;
    logic [CHAR_W-1:0] ascii_char;
    logic [LEN_W-1:0]  text_length;
    logic              last_char;

    text_char_t pending_chars[$];   // characters still owed by the core, oldest first
    int         mismatches = 0;
    int         cycle_count = 0;
    int         burst_left = 0;

    // Directed table. An empty text means the row is checked against the text builder.
    logic [NUM_W-1:0] dir_num [DIR_N] = '{
        64'd0,
        64'd1,
        -64'sd1,
        64'd9,
        64'd10,
        -64'sd10,
        -64'sd5,
        64'd12345,
        -64'sd1234567890,
        64'd1000000000000,
        -64'sd1000000000000,
        -64'sd999999999999,
        64'd999999999999999999,
        64'd1000000000000000000,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0001,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0000_FFFF_FFFF,
        64'hFFFF_FFFF_0000_0000,
        64'd99999
    };
    string dir_text [DIR_N] = '{
        "0",
        "1",
        "-1",
        "9",
        "10",
        "-10",
        "-5",
        "12345",
        "-1234567890",
        "1000000000000",
        "-1000000000000",
        "-999999999999",
        "999999999999999999",
        "1000000000000000000",
        "9223372036854775807",
        "-9223372036854775808",
        "-9223372036854775807",
        "",
        "",
        "",
        "",
        ""
    };

    signed_int64_to_decimal_ascii_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .number      (number),
        .char_valid  (char_valid),
        .ascii_char  (ascii_char),
        .text_length (text_length),
        .last_char   (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Text builder: sign, then digits most significant first. The magnitude is the
    // modulo-2^64 negation, so the most negative value needs no special handling.
    function automatic void queue_decimal_text(input logic [NUM_W-1:0] value);
        logic             negative;
        logic [NUM_W-1:0] magnitude;
        logic [3:0]       digit_lsf [DIGITS];
        int               ndigits;
        int               total;
        int               pos;
        negative  = value[NUM_W-1];
        magnitude = negative ? (~value + 1'b1) : value;
        ndigits   = 0;
        do
        begin
            digit_lsf[ndigits] = 4'(magnitude % 10);
            magnitude          = magnitude / 10;
            ndigits++;
        end
        while (magnitude != 0 && ndigits < DIGITS);
        total = ndigits + (negative ? 1 : 0);
        pos   = 0;
        if (negative)
        begin
            pending_chars.push_back('{CH_MINUS, LEN_W'(total), total == 1});
            pos = 1;
        end
        for (int i = ndigits - 1; i >= 0; i--)
        begin
            pending_chars.push_back('{CH_ZERO + CHAR_W'(digit_lsf[i]), LEN_W'(total),
                                      pos == total - 1});
            pos++;
        end
    endfunction

    // Expected text typed in as a string
    function automatic void queue_typed_text(input string text);
        byte code;
        for (int i = 0; i < text.len(); i++)
        begin
            code = text[i];
            pending_chars.push_back('{code[CHAR_W-1:0], LEN_W'(text.len()),
                                      i == text.len() - 1});
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Character checker. Outputs are read on the edge, before this edge's updates land.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && char_valid)
        begin
            if (pending_chars.size() == 0)
            begin
                report_mismatch("unexpected character", int'(ascii_char), -1);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (ascii_char !== want.ch)
                    report_mismatch("ascii_char", int'(ascii_char), int'(want.ch));
                if (text_length !== want.len)
                    report_mismatch("text_length", int'(text_length), int'(want.len));
                if (last_char !== want.last)
                    report_mismatch("last_char", int'(last_char), int'(want.last));
            end
        end
    end

    // Offer one number and hold it until the core takes it. Call right after an edge.
    task automatic send_number(input logic [NUM_W-1:0] value, input string text);
        start  <= 1'b1;
        number <= value;
        do @(posedge clk); while (busy);
        // taken on this edge: book the characters it owes
        if (text.len() != 0)
            queue_typed_text(text);
        else
            queue_decimal_text(value);
    endtask

    // Burst pacing: keep start high inside a burst, else drop it for a random gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 6);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
            start  <= 1'b0;
            number <= {$urandom, $urandom};   // noise while idle
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [NUM_W-1:0] random_number();
        shape_t           shape;
        logic [NUM_W-1:0] value;
        logic [NUM_W-1:0] decade;
        shape = shape_t'($urandom_range(int'(SHAPE_FULL), int'(SHAPE_EDGE)));
        case (shape)
            SHAPE_FULL:   value = {$urandom, $urandom};
            SHAPE_SHORT:  value = NUM_W'($urandom_range(0, 1000));
            SHAPE_DECADE:
            begin
                decade = 1;
                repeat ($urandom_range(0, 18)) decade = decade * 10;
                value = decade + NUM_W'($urandom_range(0, 2)) - 1;
            end
            SHAPE_SCALED: value = {$urandom, $urandom} >> $urandom_range(1, 63);
            default:
            begin
                value = 64'h7FFF_FFFF_FFFF_FFFF - NUM_W'($urandom_range(0, 50));
                if ($urandom_range(0, 1) == 1)
                    value = ~value;   // lands at or just above the most negative value
                return value;
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            value = ~value + 1'b1;
        return value;
    endfunction

    // Main sequence. The directed table comes first; rows with an obvious text carry it
    // typed in, the rest go through the text builder. Then about 220 random numbers of
    // mixed shape follow. The sender works in bursts with start held high from item to
    // item, and random gaps with noise on number between bursts, so start arrives at
    // every phase of a conversion.
    initial
    begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            send_number(dir_num[i], dir_text[i]);
            pace_sender();
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            send_number(random_number(), "");
            pace_sender();
        end

        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_CAP) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/i64dec_pkg.sv
rtl/i64dec_conv.sv
rtl/signed_int64_to_decimal_ascii_core.sv
rtl/i64dec_check.sv
bench/tb_top.sv
